// File: rtl/core/mmef_pkg.sv
// Shared types and constants for the multichannel median / smoothing filter.
// No dependencies; compiled first.
package mmef_pkg;

    // Default geometry
    localparam int CHANNELS_DEF = 11;
    localparam int WINDOW_DEF   = 5;

    // Field widths
    localparam int ID_W   = 16;
    localparam int CM_W   = 16;
    localparam int CH_W   = 4;
    localparam int FQ_W   = 24;
    localparam int GAIN_W = 9;
    localparam int FRAC_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0] GAIN_ONE      = 9'd256;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 9'd205;
    localparam logic [CM_W-1:0]   NO_ECHO_RST   = 16'd200;
    localparam logic [ID_W-1:0]   FIRST_ID_RST  = 16'd555;

    // Rounding constant for the Q8 blend (one half of a result LSB)
    localparam logic [33:0] BLEND_ROUND = 34'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 2'd0,
        CFG_NO_ECHO  = 2'd1,
        CFG_FIRST_ID = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_MUL_NEW,
        ST_MUL_OLD,
        ST_SUM,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        BL_HOLD,
        BL_MUL_NEW,
        BL_MUL_OLD,
        BL_SUM
    } t_blend_op;

    typedef struct packed {
        logic clr;
        logic ins;
    } t_sort_ctl;

endpackage

// File: rtl/core/mmef_ifs.sv
// Valid/ready channel interfaces: sensor item in, filter result out, config write.
// Depends on mmef_pkg.
interface mmef_in_if import mmef_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] message_id;
    logic [CM_W-1:0] reading_cm;

    modport source (output valid, output message_id, output reading_cm, input ready);
    modport sink   (input valid, input message_id, input reading_cm, output ready);
endinterface

interface mmef_out_if import mmef_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] channel;
    logic [CM_W-1:0] median_cm;
    logic [FQ_W-1:0] filtered_q8;

    modport source (output valid, output channel, output median_cm, output filtered_q8,
                    input ready);
    modport sink   (input valid, input channel, input median_cm, input filtered_q8,
                    output ready);
endinterface

interface mmef_cfg_if import mmef_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/multichannel_median_ema_filter.sv
// Multichannel median-of-window filter with Q8 exponential smoothing.
// Channels: i_in (message_id, reading_cm), o_out (channel, median_cm,
// filtered_q8), i_cfg (index, data) for gain, no-echo distance, first id.
// All are valid/ready; a transfer happens when both are high on i_clk.
// An item whose id maps to no channel is dropped after the decode cycle.
// A mapped item runs through decode, memory write, one registered memory
// read per window slot into the insertion sorter, a drain step, then three
// blend steps on the shared multiplier and a result step before o_out.valid.
// i_in.ready is high only while the sequencer is idle, so one item runs at a
// time; a new item is taken only after the last one leaves the result step.
// The result sits in an output register; a new item may start while it
// waits, and the sequencer holds its result step until o_out is free.
// Reset (i_rst_n low, synchronous) restores register defaults, clears
// filtered values and slot pointers, and marks every window empty so that
// unwritten samples read as zero. i_cfg is always ready; write it only
// while the block is idle.
module multichannel_median_ema_filter import mmef_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int WINDOW   = WINDOW_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mmef_in_if.sink      i_in,
    mmef_cfg_if.sink     i_cfg,
    mmef_out_if.source   o_out
);

    localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = $clog2(WINDOW);
    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(CHANNELS * WINDOW);
    localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW - 1);

    t_state r_state, n_state;

    // Config registers
    logic [GAIN_W-1:0] r_gain;
    logic [CM_W-1:0]   r_no_echo;
    logic [ID_W-1:0]   r_first;

    // Per-channel state
    logic [SW-1:0]   r_wslot [CHANNELS];
    logic            r_full  [CHANNELS];
    logic [FQ_W-1:0] r_filt  [CHANNELS];

    // Current item
    logic [ID_W-1:0] r_id;
    logic [CM_W-1:0] r_raw;
    logic [CM_W-1:0] r_val;
    logic [CH_W-1:0] r_ch;
    logic [AW-1:0]   r_base;
    logic [SW-1:0]   r_slot;
    logic            r_full_cur;
    logic [SW-1:0]   r_idx;
    logic            r_ins_en;
    logic [SW-1:0]   r_ins_slot;

    // Output register
    logic            r_out_valid;
    logic [CH_W-1:0] r_out_ch;
    logic [CM_W-1:0] r_out_med;
    logic [FQ_W-1:0] r_out_filt;

    logic [ID_W:0]   w_diff;
    logic            w_hit;
    logic [CIW-1:0]  w_ch_idx;
    logic [CIW-1:0]  w_cur;
    logic            w_out_free;
    logic            w_mem_we;
    logic [AW-1:0]   w_mem_addr;
    logic [CM_W-1:0] w_mem_q;
    logic [CM_W-1:0] w_sort_din;
    logic [CM_W-1:0] w_median;
    logic [FQ_W-1:0] w_blend;
    t_sort_ctl       w_sort_ctl;
    t_blend_op       w_blend_op;

    // Id decode; no wrap of the id range
    assign w_diff   = {1'b0, r_id} - {1'b0, r_first};
    assign w_hit    = !w_diff[ID_W] && (w_diff[ID_W-1:0] < ID_W'(CHANNELS));
    assign w_ch_idx = w_diff[CIW-1:0];
    assign w_cur    = r_ch[CIW-1:0];

    assign w_out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.channel     = r_out_ch;
    assign o_out.median_cm   = r_out_med;
    assign o_out.filtered_q8 = r_out_filt;

    // Slots past the fill point have never been written and count as zero
    assign w_sort_din = (r_full_cur || (r_ins_slot <= r_slot)) ? w_mem_q : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_in.valid) n_state = ST_CHECK;
            ST_CHECK:   n_state = w_hit ? ST_WRITE : ST_IDLE;
            ST_WRITE:   n_state = ST_READ;
            ST_READ:    if (r_idx == SLOT_LAST) n_state = ST_DRAIN;
            ST_DRAIN:   n_state = ST_MUL_NEW;
            ST_MUL_NEW: n_state = ST_MUL_OLD;
            ST_MUL_OLD: n_state = ST_SUM;
            ST_SUM:     n_state = ST_DONE;
            ST_DONE:    if (w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_mem_we       = 1'b0;
        w_mem_addr     = r_base + AW'(r_idx);
        w_sort_ctl.clr = 1'b0;
        w_sort_ctl.ins = r_ins_en;
        w_blend_op     = BL_HOLD;
        unique case (r_state)
            ST_WRITE: begin
                w_mem_we       = 1'b1;
                w_mem_addr     = r_base + AW'(r_slot);
                w_sort_ctl.clr = 1'b1;
            end
            ST_MUL_NEW: w_blend_op = BL_MUL_NEW;
            ST_MUL_OLD: w_blend_op = BL_MUL_OLD;
            ST_SUM:     w_blend_op = BL_SUM;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gain      <= GAIN_RST;
            r_no_echo   <= NO_ECHO_RST;
            r_first     <= FIRST_ID_RST;
            r_ins_en    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wslot[c] <= '0;
                r_full[c]  <= 1'b0;
                r_filt[c]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ins_en <= (r_state == ST_READ);

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_GAIN:     r_gain    <= i_cfg.data[GAIN_W-1:0];
                    CFG_NO_ECHO:  r_no_echo <= i_cfg.data;
                    CFG_FIRST_ID: r_first   <= i_cfg.data;
                    default: begin
                    end
                endcase
            end

            if (r_state == ST_WRITE) begin
                r_wslot[w_cur] <= (r_slot == SLOT_LAST) ? '0 : r_slot + SW'(1);
                if (r_slot == SLOT_LAST) begin
                    r_full[w_cur] <= 1'b1;
                end
            end

            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid    <= 1'b1;
                r_filt[w_cur]  <= w_blend;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in.valid) begin
            r_id  <= i_in.message_id;
            r_raw <= i_in.reading_cm;
        end
        if (r_state == ST_CHECK) begin
            r_ch       <= CH_W'(w_ch_idx);
            r_base     <= AW'(w_ch_idx) * AW'(WINDOW);
            r_val      <= (r_raw == '0) ? r_no_echo : r_raw;
            r_slot     <= r_wslot[w_ch_idx];
            r_full_cur <= r_full[w_ch_idx];
        end
        if (r_state == ST_WRITE) begin
            r_idx <= '0;
        end else if (r_state == ST_READ) begin
            r_idx <= r_idx + SW'(1);
        end
        r_ins_slot <= r_idx;
        if (r_state == ST_DONE && w_out_free) begin
            r_out_ch   <= r_ch;
            r_out_med  <= w_median;
            r_out_filt <= w_blend;
        end
    end

    mmef_win_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (r_val),
        .o_rdata (w_mem_q)
    );

    mmef_sorter #(
        .WINDOW (WINDOW)
    ) u_sorter (
        .i_clk    (i_clk),
        .i_ctl    (w_sort_ctl),
        .i_din    (w_sort_din),
        .o_median (w_median)
    );

    mmef_blend u_blend (
        .i_clk    (i_clk),
        .i_op     (w_blend_op),
        .i_gain   (r_gain),
        .i_median (w_median),
        .i_prev   (r_filt[w_cur]),
        .o_result (w_blend)
    );

endmodule

// File: rtl/core/mmef_win_mem.sv
// Window sample memory: one port, a registered read every cycle plus an optional
// write (a read during a write returns the old word). Depends on mmef_pkg.
module mmef_win_mem import mmef_pkg::*; #(
    parameter int DEPTH = CHANNELS_DEF * WINDOW_DEF,
    parameter int AW    = $clog2(CHANNELS_DEF * WINDOW_DEF)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_addr,
    input  logic [CM_W-1:0] i_wdata,
    output logic [CM_W-1:0] o_rdata
);

    logic [CM_W-1:0] r_mem [DEPTH];
    logic [CM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/mmef_sorter.sv
// Insertion sorter: one sample enters the sorted row per cycle while ins is set,
// median tapped from the middle cell. Depends on mmef_pkg.
module mmef_sorter import mmef_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic            i_clk,
    input  t_sort_ctl       i_ctl,
    input  logic [CM_W-1:0] i_din,
    output logic [CM_W-1:0] o_median
);

    // Top bit marks an empty cell, which sorts above any sample.
    logic [CM_W:0] r_s [WINDOW];
    logic [CM_W:0] n_s [WINDOW];
    logic [WINDOW-1:0] w_gt;
    logic [CM_W:0]     w_din;

    assign w_din = {1'b0, i_din};

    always_comb begin
        for (int j = 0; j < WINDOW; j++) begin
            w_gt[j] = r_s[j] > w_din;
        end
    end

    always_comb begin
        for (int j = 0; j < WINDOW; j++) begin
            n_s[j] = r_s[j];
        end
        if (i_ctl.clr) begin
            for (int j = 0; j < WINDOW; j++) begin
                n_s[j] = {1'b1, {CM_W{1'b0}}};
            end
        end else if (i_ctl.ins) begin
            if (w_gt[0]) begin
                n_s[0] = w_din;
            end
            for (int j = 1; j < WINDOW; j++) begin
                if (w_gt[j]) begin
                    n_s[j] = w_gt[j-1] ? r_s[j-1] : w_din;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < WINDOW; j++) begin
            r_s[j] <= n_s[j];
        end
    end

    assign o_median = r_s[WINDOW/2][CM_W-1:0];

endmodule

// File: rtl/core/mmef_blend.sv
// Q8 exponential blend on one shared 9x24 multiplier over three steps:
// g*median, (1-g)*prev with rounding, then the sum. Depends on mmef_pkg.
module mmef_blend import mmef_pkg::*; (
    input  logic              i_clk,
    input  t_blend_op         i_op,
    input  logic [GAIN_W-1:0] i_gain,
    input  logic [CM_W-1:0]   i_median,
    input  logic [FQ_W-1:0]   i_prev,
    output logic [FQ_W-1:0]   o_result
);

    logic [GAIN_W-1:0] w_g;
    logic [GAIN_W-1:0] w_mul_a;
    logic [FQ_W-1:0]   w_mul_b;
    logic [32:0]       w_prod;
    logic [32:0]       r_prod;
    logic [33:0]       r_acc;

    assign w_g = (i_gain > GAIN_ONE) ? GAIN_ONE : i_gain;

    always_comb begin
        unique case (i_op)
            BL_MUL_OLD: begin
                w_mul_a = GAIN_ONE - w_g;
                w_mul_b = i_prev;
            end
            default: begin
                w_mul_a = w_g;
                w_mul_b = {i_median, {FRAC_W{1'b0}}};
            end
        endcase
    end

    assign w_prod = {24'b0, w_mul_a} * {9'b0, w_mul_b};

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            BL_MUL_NEW: begin
                r_prod <= w_prod;
            end
            BL_MUL_OLD: begin
                r_prod <= w_prod;
                r_acc  <= {1'b0, r_prod} + BLEND_ROUND;
            end
            BL_SUM: begin
                r_acc  <= r_acc + {1'b0, r_prod};
            end
            default: begin
            end
        endcase
    end

    assign o_result = r_acc[FRAC_W +: FQ_W];

endmodule
